/* rtl/glos_pkg.sv */
// Shared constants and controller/datapath interface types for the line-of-sight grid.
package glos_pkg;

    localparam int GRID_SIZE = 8;
    localparam int COORD_W = 3;
    localparam int IDX_W = $clog2(GRID_SIZE);
    localparam int CODE_W = 4;
    localparam int GUARD_W = COORD_W + 1;
    localparam int ERR_W = COORD_W + 3;

    localparam logic [CODE_W-1:0] OBSTACLE_CODE = 4'd9;
    localparam logic [COORD_W:0] GRID_LIMIT = (COORD_W + 1)'(GRID_SIZE);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic write_cell;
        logic load_query;
        logic step;
        logic set_result;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic at_end;
        logic last_step;
    } dp_sts_t;

endpackage

/* rtl/glos_ctrl.sv */
// Controller state machine: input/output handshake and sequencing of the line walk.
module glos_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              op,
    input  logic              out_stall,
    input  glos_pkg::dp_sts_t sts,
    output logic              in_stall,
    output logic              out_valid,
    output glos_pkg::dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_busy;
    logic in_take;
    logic walk_done;

    assign out_busy  = out_valid_reg & out_stall;
    assign in_stall  = (state_reg != ST_IDLE) | out_busy;
    assign in_take   = in_valid & ~in_stall;
    assign walk_done = sts.hit | sts.at_end | sts.last_step;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (op == glos_pkg::OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        cmd.write_cell = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                if (!walk_done)
                begin
                    cmd.step = 1'b1;
                end
                else if (!out_busy)
                begin
                    cmd.set_result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_busy | cmd.set_result | cmd.write_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/glos_datapath.sv */
// Datapath: obstacle grid storage, Bresenham walk registers and result register.
module glos_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  glos_pkg::dp_cmd_t              cmd,
    input  logic [glos_pkg::COORD_W-1:0]   from_x,
    input  logic [glos_pkg::COORD_W-1:0]   from_y,
    input  logic [glos_pkg::COORD_W-1:0]   to_x,
    input  logic [glos_pkg::COORD_W-1:0]   to_y,
    input  logic [glos_pkg::CODE_W-1:0]    cell_code,
    output glos_pkg::dp_sts_t              sts,
    output logic                           done_kind,
    output logic                           path_blocked
);

    localparam int CW = glos_pkg::COORD_W;
    localparam int EW = glos_pkg::ERR_W;
    localparam int GW = glos_pkg::GUARD_W;

    logic [glos_pkg::GRID_SIZE-1:0] map_reg [glos_pkg::GRID_SIZE];

    logic [CW-1:0]        x_reg;
    logic [CW-1:0]        y_reg;
    logic [CW-1:0]        ex_reg;
    logic [CW-1:0]        ey_reg;
    logic [CW-1:0]        dx_reg;
    logic [CW-1:0]        dy_reg;
    logic                 sx_reg;
    logic                 sy_reg;
    logic signed [EW-1:0] err_reg;
    logic [GW-1:0]        guard_reg;
    logic                 done_kind_reg;
    logic                 blocked_reg;

    logic [CW-1:0]        in_dx;
    logic [CW-1:0]        in_dy;
    logic [CW-1:0]        in_max;
    logic                 wr_in_grid;
    logic                 cur_in_grid;
    logic [glos_pkg::GRID_SIZE-1:0] cur_row;
    logic signed [EW:0]   e2;
    logic signed [EW:0]   neg_dy;
    logic signed [EW:0]   dx_ext;
    logic                 step_x;
    logic                 step_y;
    logic signed [EW-1:0] err_next;

    assign in_dx  = (to_x > from_x) ? (to_x - from_x) : (from_x - to_x);
    assign in_dy  = (to_y > from_y) ? (to_y - from_y) : (from_y - to_y);
    assign in_max = (in_dx > in_dy) ? in_dx : in_dy;

    assign wr_in_grid  = ({1'b0, from_x} < glos_pkg::GRID_LIMIT) &&
                         ({1'b0, from_y} < glos_pkg::GRID_LIMIT);
    assign cur_in_grid = ({1'b0, x_reg} < glos_pkg::GRID_LIMIT) &&
                         ({1'b0, y_reg} < glos_pkg::GRID_LIMIT);
    assign cur_row     = map_reg[y_reg[glos_pkg::IDX_W-1:0]];

    assign sts.hit       = cur_in_grid & cur_row[x_reg[glos_pkg::IDX_W-1:0]];
    assign sts.at_end    = (x_reg == ex_reg) && (y_reg == ey_reg);
    assign sts.last_step = (guard_reg == GW'(1));

    assign e2     = {err_reg, 1'b0};
    assign neg_dy = -$signed({{(EW + 1 - CW){1'b0}}, dy_reg});
    assign dx_ext = $signed({{(EW + 1 - CW){1'b0}}, dx_reg});
    assign step_x = e2 > neg_dy;
    assign step_y = e2 < dx_ext;

    always_comb
    begin
        err_next = err_reg;
        if (step_x)
        begin
            err_next = err_next - $signed({{(EW - CW){1'b0}}, dy_reg});
        end
        if (step_y)
        begin
            err_next = err_next + $signed({{(EW - CW){1'b0}}, dx_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < glos_pkg::GRID_SIZE; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (cmd.write_cell && wr_in_grid)
        begin
            map_reg[from_y[glos_pkg::IDX_W-1:0]][from_x[glos_pkg::IDX_W-1:0]] <=
                (cell_code == glos_pkg::OBSTACLE_CODE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            x_reg     <= from_x;
            y_reg     <= from_y;
            ex_reg    <= to_x;
            ey_reg    <= to_y;
            dx_reg    <= in_dx;
            dy_reg    <= in_dy;
            sx_reg    <= from_x < to_x;
            sy_reg    <= from_y < to_y;
            err_reg   <= $signed({{(EW - CW){1'b0}}, in_dx})
                       - $signed({{(EW - CW){1'b0}}, in_dy});
            guard_reg <= {1'b0, in_max} + GW'(1);
        end
        else if (cmd.step)
        begin
            if (step_x)
            begin
                x_reg <= sx_reg ? (x_reg + CW'(1)) : (x_reg - CW'(1));
            end
            if (step_y)
            begin
                y_reg <= sy_reg ? (y_reg + CW'(1)) : (y_reg - CW'(1));
            end
            err_reg   <= err_next;
            guard_reg <= guard_reg - GW'(1);
        end

        if (cmd.write_cell)
        begin
            done_kind_reg <= glos_pkg::OP_WRITE;
            blocked_reg   <= 1'b0;
        end
        else if (cmd.set_result)
        begin
            done_kind_reg <= glos_pkg::OP_QUERY;
            blocked_reg   <= sts.hit;
        end
    end

    assign done_kind    = done_kind_reg;
    assign path_blocked = blocked_reg;

endmodule

/* rtl/grid_line_of_sight_core.sv */
// Top level of the obstacle grid with Bresenham line-of-sight queries.
//
// Input channel (in_valid/in_stall) carries one item: op, from_x, from_y,
// to_x, to_y, cell_code. op 0 writes one cell of the 8x8 grid (code 9 marks
// an obstacle, any other code clears it); op 1 asks whether any cell on the
// Bresenham line from (from_x, from_y) to (to_x, to_y) is an obstacle.
// Output channel (out_valid/out_stall) returns one item per input item:
// done_kind echoes op, path_blocked gives the query answer (0 for writes).
// A write's result is valid the cycle after acceptance.
// A query walks one cell per cycle through the controller/datapath loop,
// visiting the cells up to the first obstacle or its end point, at most
// max(|dx|,|dy|) + 1 = 8 of them; the next item is taken after
// that. Results sit in an output register; an item is taken only while that
// register is empty or its result leaves in the same cycle, so a stalled
// result holds and stalls the input until the receiver takes it. Reset
// clears every cell of the grid at once and empties the output register.
module grid_line_of_sight_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic [glos_pkg::COORD_W-1:0]       from_x,
    input  logic [glos_pkg::COORD_W-1:0]       from_y,
    input  logic [glos_pkg::COORD_W-1:0]       to_x,
    input  logic [glos_pkg::COORD_W-1:0]       to_y,
    input  logic [glos_pkg::CODE_W-1:0]        cell_code,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               done_kind,
    output logic                               path_blocked
);

    glos_pkg::dp_cmd_t cmd;
    glos_pkg::dp_sts_t sts;

    glos_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    glos_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .from_x       (from_x),
        .from_y       (from_y),
        .to_x         (to_x),
        .to_y         (to_y),
        .cell_code    (cell_code),
        .sts          (sts),
        .done_kind    (done_kind),
        .path_blocked (path_blocked)
    );

endmodule

/* rtl/glos_checker.sv */
// Port-level assertions for the line-of-sight core and their binding.
module glos_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         op,
    input logic [glos_pkg::COORD_W-1:0] from_x,
    input logic [glos_pkg::COORD_W-1:0] from_y,
    input logic [glos_pkg::COORD_W-1:0] to_x,
    input logic [glos_pkg::COORD_W-1:0] to_y,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         done_kind,
    input logic                         path_blocked
);

    logic in_take;

    assign in_take = in_valid & ~in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(done_kind) && $stable(path_blocked))
        else $error("stalled result changed");

    a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (op == glos_pkg::OP_WRITE) |=>
            out_valid && (done_kind == glos_pkg::OP_WRITE) && !path_blocked)
        else $error("write not acknowledged next cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (op == glos_pkg::OP_QUERY) |=> in_stall)
        else $error("input taken during query walk");

    a_single_cell: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (op == glos_pkg::OP_QUERY) && (from_x == to_x) && (from_y == to_y)
            |=> ##1 out_valid && (done_kind == glos_pkg::OP_QUERY))
        else $error("single-cell query not answered in two cycles");

    a_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (done_kind == glos_pkg::OP_WRITE) |-> !path_blocked)
        else $error("write result flagged blocked");

endmodule

bind grid_line_of_sight_core glos_checker u_glos_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .from_x       (from_x),
    .from_y       (from_y),
    .to_x         (to_x),
    .to_y         (to_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .done_kind    (done_kind),
    .path_blocked (path_blocked)
);
